// ----- rtl/core/stbd_pkg.sv -----
// Shared types and constants for the slope trend boost detector.
package stbd_pkg;

  localparam int LEVEL_W = 16;
  localparam int TIME_W  = 32;
  localparam int DIFF_W  = LEVEL_W + 1;
  localparam int SLOPE_W = 24;
  localparam int GAIN_W  = 16;
  localparam int RUN_W   = 10;

  localparam logic [RUN_W-1:0]  COUNT_MAX = 10'd1023;

  localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd46;
  localparam logic [RUN_W-1:0]  TO_BOOST_RST  = 10'd400;
  localparam logic [RUN_W-1:0]  TO_NORMAL_RST = 10'd40;

  localparam logic [1:0] REG_GAIN      = 2'd0;
  localparam logic [1:0] REG_TO_BOOST  = 2'd1;
  localparam logic [1:0] REG_TO_NORMAL = 2'd2;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [TIME_W-1:0]        dt;
  } stbd_item_t;

  typedef struct packed {
    logic       valid;
    stbd_item_t item;
  } stbd_beat_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [RUN_W-1:0]  to_boost;
    logic [RUN_W-1:0]  to_normal;
  } stbd_cfg_t;

endpackage

// ----- rtl/core/stbd_front.sv -----
// Front end: accepts samples and forms level and time differences.
module stbd_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [stbd_pkg::LEVEL_W-1:0]  in_level_sample,
  input  logic [stbd_pkg::TIME_W-1:0]          in_time_ms,
  input  logic                                 q_full,
  output stbd_pkg::stbd_beat_t                 push
);

  logic signed [stbd_pkg::LEVEL_W-1:0] prev_level_r;
  logic [stbd_pkg::TIME_W-1:0]         prev_time_r;
  logic                                take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    push.valid     = take;
    push.item.diff = {in_level_sample[stbd_pkg::LEVEL_W-1], in_level_sample}
                   - {prev_level_r[stbd_pkg::LEVEL_W-1], prev_level_r};
    push.item.dt   = in_time_ms - prev_time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= '0;
      prev_time_r  <= '0;
    end else if (take) begin
      prev_level_r <= in_level_sample;
      prev_time_r  <= in_time_ms;
    end
  end

endmodule

// ----- rtl/core/stbd_queue.sv -----
// Two-entry queue between the front end and the back end.
module stbd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stbd_pkg::stbd_beat_t push,
  output logic                 q_full,
  output stbd_pkg::stbd_beat_t q,
  input  logic                 q_pop
);

  stbd_pkg::stbd_item_t mem_r [2];
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  logic [1:0]           count_r;
  logic [1:0]           count_nxt;

  assign q_full  = (count_r == 2'd2);
  assign q.valid = (count_r != 2'd0);
  assign q.item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push.valid && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

endmodule

// ----- rtl/core/stbd_back.sv -----
// Back end: serial slope divider, IIR smoother, mode machine and result register.
module stbd_back #(
  parameter int SLOPE_FRAC_BITS = 8,
  parameter int GAIN_FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  stbd_pkg::stbd_beat_t                 q,
  output logic                                 q_pop,
  input  stbd_pkg::stbd_cfg_t                  cfg,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [stbd_pkg::SLOPE_W-1:0]  out_smoothed_slope,
  output logic                                 out_boost_active
);

  localparam int SW    = stbd_pkg::SLOPE_W;
  localparam int GW    = stbd_pkg::GAIN_W;
  localparam int TW    = stbd_pkg::TIME_W;
  localparam int DW    = stbd_pkg::DIFF_W;
  localparam int RW    = stbd_pkg::RUN_W;
  localparam int FW    = SW + GAIN_FRAC_BITS;
  localparam int P10_W = DW + 4;
  localparam int NUM_W = P10_W + SLOPE_FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int QX_W  = (NUM_W > SW) ? NUM_W : SW + 1;
  localparam int PA_W  = SW + 1 + GW;
  localparam int MAG_W = PA_W + 1;
  localparam int PB_W  = GW + 1;
  localparam int BP_W  = GAIN_FRAC_BITS + GW + 1;
  localparam int SUM_W = ((FW > MAG_W) ? FW : MAG_W) + 2;

  localparam logic [QX_W-1:0] POS_LIM = QX_W'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic [QX_W-1:0] NEG_LIM = QX_W'(64'd1 << (SW - 1));
  localparam logic [BP_W-1:0] FMASK   = BP_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SLOPE = 3'd2;
  localparam logic [2:0] S_DIFF  = 3'd3;
  localparam logic [2:0] S_MULA  = 3'd4;
  localparam logic [2:0] S_MULB  = 3'd5;
  localparam logic [2:0] S_ACC   = 3'd6;
  localparam logic [2:0] S_MODE  = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        div_cnt_r;
  logic [NUM_W-1:0]        nq_r;
  logic [TW-1:0]           rem_r;
  logic [TW-1:0]           dmag_r;
  logic                    sneg_r;
  logic                    dzero_r;
  logic [SW-1:0]           slope_r;
  logic [FW:0]             m_r;
  logic                    dn_r;
  logic [PA_W-1:0]         pa_r;
  logic [PB_W-1:0]         pb_r;
  logic [FW-1:0]           filt_r;
  logic [RW-1:0]           run_r;
  logic                    boost_r;
  logic                    outv_r;
  logic [SW-1:0]           out_slope_r;
  logic                    out_boost_r;

  logic [DW-1:0]           absd;
  logic [P10_W-1:0]        prod10;
  logic [TW-1:0]           dmag_init;
  logic [TW:0]             rem_sh;
  logic                    qbit;
  logic [TW-1:0]           rem_nxt;
  logic [QX_W-1:0]         q_x, qc, qn;
  logic [SW-1:0]           slope_calc;
  logic [FW:0]             d_calc, m_calc;
  logic [BP_W-1:0]         bp;
  logic [MAG_W-1:0]        mag;
  logic [SUM_W-1:0]        magx, dlt, sum;
  logic [SUM_W-FW:0]       top;
  logic [FW-1:0]           filt_nxt;
  logic                    neg, counts, load;
  logic [RW-1:0]           thr, run_inc;

  assign q_pop = (state_r == S_IDLE) && q.valid;
  assign load  = (state_r == S_MODE) && (!outv_r || out_ready);

  always_comb begin
    absd      = q.item.diff[DW-1] ? DW'(-q.item.diff) : DW'(q.item.diff);
    prod10    = P10_W'(absd) * P10_W'(10);
    dmag_init = q.item.dt[TW-1] ? (~q.item.dt + 1'b1) : q.item.dt;

    rem_sh  = {rem_r, nq_r[NUM_W-1]};
    qbit    = (rem_sh >= {1'b0, dmag_r});
    rem_nxt = qbit ? TW'(rem_sh - {1'b0, dmag_r}) : rem_sh[TW-1:0];

    q_x = QX_W'(nq_r);
    if (sneg_r) begin
      qc = (q_x > NEG_LIM) ? NEG_LIM : q_x;
      qn = ~qc + 1'b1;
    end else begin
      qc = (q_x > POS_LIM) ? POS_LIM : q_x;
      qn = qc;
    end
    slope_calc = dzero_r ? '0 : qn[SW-1:0];

    d_calc = {slope_r[SW-1], slope_r, {GAIN_FRAC_BITS{1'b0}}} - {filt_r[FW-1], filt_r};
    m_calc = d_calc[FW] ? (~d_calc + 1'b1) : d_calc;

    bp = BP_W'(m_r[GAIN_FRAC_BITS-1:0]) * BP_W'(cfg.gain) + (dn_r ? FMASK : '0);

    mag  = MAG_W'(pa_r) + MAG_W'(pb_r);
    magx = SUM_W'(mag);
    dlt  = dn_r ? (~magx + 1'b1) : magx;
    sum  = {{(SUM_W-FW){filt_r[FW-1]}}, filt_r} + dlt;
    top  = sum[SUM_W-1:FW-1];
    if ((&top) || !(|top)) begin
      filt_nxt = sum[FW-1:0];
    end else if (sum[SUM_W-1]) begin
      filt_nxt = {1'b1, {(FW-1){1'b0}}};
    end else begin
      filt_nxt = {1'b0, {(FW-1){1'b1}}};
    end

    neg     = filt_r[FW-1];
    counts  = boost_r ? neg : !neg;
    thr     = boost_r ? cfg.to_normal : cfg.to_boost;
    run_inc = counts ? ((run_r < stbd_pkg::COUNT_MAX) ? run_r + 1'b1 : run_r) : '0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q.valid) state_nxt = S_DIV;
      S_DIV:   if (div_cnt_r == CNT_W'(NUM_W - 1)) state_nxt = S_SLOPE;
      S_SLOPE: state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MULA;
      S_MULA:  state_nxt = S_MULB;
      S_MULB:  state_nxt = S_ACC;
      S_ACC:   state_nxt = S_MODE;
      S_MODE:  if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        nq_r      <= NUM_W'(prod10) << SLOPE_FRAC_BITS;
        rem_r     <= '0;
        dmag_r    <= dmag_init;
        sneg_r    <= q.item.diff[DW-1] ^ q.item.dt[TW-1];
        dzero_r   <= (q.item.dt == '0);
        div_cnt_r <= '0;
      end
      S_DIV: begin
        rem_r     <= rem_nxt;
        nq_r      <= {nq_r[NUM_W-2:0], qbit};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      S_SLOPE: slope_r <= slope_calc;
      S_DIFF: begin
        m_r  <= m_calc;
        dn_r <= d_calc[FW];
      end
      S_MULA: pa_r <= PA_W'(m_r[FW:GAIN_FRAC_BITS]) * PA_W'(cfg.gain);
      S_MULB: pb_r <= bp[BP_W-1:GAIN_FRAC_BITS];
      S_ACC, S_MODE: ;
      default: ;
    endcase
    if (load) begin
      out_slope_r <= filt_r[FW-1:GAIN_FRAC_BITS];
      out_boost_r <= (thr <= run_inc) ? !boost_r : boost_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      filt_r  <= '0;
      run_r   <= '0;
      boost_r <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ACC) begin
        filt_r <= filt_nxt;
      end
      if (load) begin
        if (thr <= run_inc) begin
          run_r   <= '0;
          boost_r <= !boost_r;
        end else begin
          run_r <= run_inc;
        end
        outv_r <= 1'b1;
      end else if (out_ready) begin
        outv_r <= 1'b0;
      end
    end
  end

  assign out_valid          = outv_r;
  assign out_smoothed_slope = out_slope_r;
  assign out_boost_active   = out_boost_r;

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r <= CNT_W'(NUM_W - 1)))
    else $error("divider step count overran");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_DIV))
    else $error("queue pop did not start a division");

  a_load_mode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(outv_r) |-> ($past(state_r) == S_MODE))
    else $error("result loaded outside mode step");

  a_acc_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |=> (state_r == S_MODE))
    else $error("filter update not followed by mode step");

endmodule

// ----- rtl/core/slope_trend_boost_detector_top.sv -----
// Top level of the slope trend boost detector with its register port.
//
//  channel   direction  handshake                  payload
//  in        sink       in_valid / in_ready        in_level_sample, in_time_ms
//  out       source     out_valid / out_ready      out_smoothed_slope, out_boost_active
//  config    sink       psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// The back end takes a new sample only once it is through with the last; its slope
// comes from a one-bit-a-step restoring divider.
// The front end takes a sample whenever the two-entry queue has room.
// rst_n is synchronous: it clears the history, filter, run count and mode.
// A held result stalls the back end only at its last step; the queue still fills.
module slope_trend_boost_detector_top #(
  parameter int SLOPE_FRAC_BITS = 8,
  parameter int GAIN_FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [stbd_pkg::LEVEL_W-1:0]  in_level_sample,
  input  logic [stbd_pkg::TIME_W-1:0]          in_time_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [stbd_pkg::SLOPE_W-1:0]  out_smoothed_slope,
  output logic                                 out_boost_active,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [3:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  stbd_pkg::stbd_cfg_t  cfg_r;
  stbd_pkg::stbd_beat_t push;
  stbd_pkg::stbd_beat_t q;
  logic                 q_full;
  logic                 q_pop;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain      <= stbd_pkg::GAIN_RST;
      cfg_r.to_boost  <= stbd_pkg::TO_BOOST_RST;
      cfg_r.to_normal <= stbd_pkg::TO_NORMAL_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        stbd_pkg::REG_GAIN:      cfg_r.gain      <= pwdata[stbd_pkg::GAIN_W-1:0];
        stbd_pkg::REG_TO_BOOST:  cfg_r.to_boost  <= pwdata[stbd_pkg::RUN_W-1:0];
        stbd_pkg::REG_TO_NORMAL: cfg_r.to_normal <= pwdata[stbd_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      stbd_pkg::REG_GAIN:      prdata = 32'(cfg_r.gain);
      stbd_pkg::REG_TO_BOOST:  prdata = 32'(cfg_r.to_boost);
      stbd_pkg::REG_TO_NORMAL: prdata = 32'(cfg_r.to_normal);
      default:                 prdata = '0;
    endcase
  end

  stbd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_level_sample (in_level_sample),
    .in_time_ms      (in_time_ms),
    .q_full          (q_full),
    .push            (push)
  );

  stbd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .q      (q),
    .q_pop  (q_pop)
  );

  stbd_back #(
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q                  (q),
    .q_pop              (q_pop),
    .cfg                (cfg_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_smoothed_slope (out_smoothed_slope),
    .out_boost_active   (out_boost_active)
  );

endmodule

// ----- tb/tb_slope_trend_boost_detector_top.sv -----
// Testbench for slope_trend_boost_detector_top: directed and random samples against a predictor.
`timescale 1ns / 1ps

module tb_slope_trend_boost_detector_top;

  localparam int SLOPE_FRAC = 8;
  localparam int GAIN_FRAC  = 16;
  localparam longint SLOPE_HI = (64'sd1 <<< (stbd_pkg::SLOPE_W - 1)) - 1;
  localparam longint SLOPE_LO = -SLOPE_HI - 1;
  localparam longint FILT_HI  = (64'sd1 <<< (stbd_pkg::SLOPE_W + GAIN_FRAC - 1)) - 1;
  localparam longint FILT_LO  = -FILT_HI - 1;
  localparam longint unsigned FRAC_MASK = (64'd1 << GAIN_FRAC) - 1;
  localparam longint unsigned DT_SPAN   = 64'h1_0000_0000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic signed [stbd_pkg::SLOPE_W-1:0] slope;
    logic                                boost;
  } trend_result_t;

  class trend_predictor;
    logic [stbd_pkg::GAIN_W-1:0]         gain;
    logic [stbd_pkg::RUN_W-1:0]          to_boost;
    logic [stbd_pkg::RUN_W-1:0]          to_normal;
    logic signed [stbd_pkg::LEVEL_W-1:0] last_level;
    logic [stbd_pkg::TIME_W-1:0]         last_stamp;
    longint                              filt;
    int unsigned                         run;
    bit                                  boost;
    trend_result_t                       expected_trend[$];
    int                                  errors;
    int                                  taken;

    function new();
      gain       = stbd_pkg::GAIN_RST;
      to_boost   = stbd_pkg::TO_BOOST_RST;
      to_normal  = stbd_pkg::TO_NORMAL_RST;
      last_level = '0;
      last_stamp = '0;
      filt       = 0;
      run        = 0;
      boost      = 1'b0;
      errors     = 0;
      taken      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        stbd_pkg::REG_GAIN:      gain = val[stbd_pkg::GAIN_W-1:0];
        stbd_pkg::REG_TO_BOOST:  to_boost = val[stbd_pkg::RUN_W-1:0];
        stbd_pkg::REG_TO_NORMAL: to_normal = val[stbd_pkg::RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint raw_slope(logic signed [stbd_pkg::LEVEL_W-1:0] level,
                               logic [stbd_pkg::TIME_W-1:0] stamp);
      logic [stbd_pkg::TIME_W-1:0] dt;
      longint                      diff;
      longint                      s;
      longint unsigned             dmag;
      longint unsigned             nmag;
      bit                          dneg;
      bit                          nneg;
      dt = stamp - last_stamp;
      if (dt == '0) return 0;
      dneg = dt[stbd_pkg::TIME_W-1];
      dmag = dneg ? (DT_SPAN - longint'(dt)) : longint'(dt);
      diff = longint'(level) - longint'(last_level);
      nneg = diff < 0;
      nmag = (nneg ? -diff : diff) * 10 * (64'sd1 <<< SLOPE_FRAC);
      s = longint'(nmag / dmag);
      if (nneg != dneg) s = -s;
      if (s > SLOPE_HI) s = SLOPE_HI;
      if (s < SLOPE_LO) s = SLOPE_LO;
      return s;
    endfunction

    function void note_sample(logic signed [stbd_pkg::LEVEL_W-1:0] level,
                              logic [stbd_pkg::TIME_W-1:0] stamp);
      longint          s;
      longint          d;
      longint          delta;
      longint unsigned m;
      longint unsigned g;
      bit              neg;
      bit              counts;
      int unsigned     thr;
      trend_result_t   want;
      s = raw_slope(level, stamp);
      last_stamp = stamp;
      last_level = level;
      d = (s <<< GAIN_FRAC) - filt;
      m = (d < 0) ? -d : d;
      g = 64'(gain);
      if (d >= 0)
        delta = longint'((m >> GAIN_FRAC) * g + (((m & FRAC_MASK) * g) >> GAIN_FRAC));
      else
        delta = -longint'((m >> GAIN_FRAC) * g
                          + (((m & FRAC_MASK) * g + FRAC_MASK) >> GAIN_FRAC));
      filt = filt + delta;
      if (filt > FILT_HI) filt = FILT_HI;
      if (filt < FILT_LO) filt = FILT_LO;
      neg    = filt < 0;
      counts = boost ? neg : !neg;
      thr    = 32'(boost ? to_normal : to_boost);
      if (counts) begin
        if (run < stbd_pkg::COUNT_MAX) run++;
      end else begin
        run = 0;
      end
      if (thr <= run) begin
        run   = 0;
        boost = !boost;
      end
      want.slope = stbd_pkg::SLOPE_W'(filt >>> GAIN_FRAC);
      want.boost = boost;
      expected_trend.push_back(want);
    endfunction

    function void check_result(logic signed [stbd_pkg::SLOPE_W-1:0] slope, logic boost_seen);
      trend_result_t want;
      taken++;
      if (expected_trend.size() == 0) begin
        $error("unexpected beat: smoothed_slope %0d boost_active %0b", slope, boost_seen);
        errors++;
        return;
      end
      want = expected_trend.pop_front();
      if (slope !== want.slope) begin
        $error("smoothed_slope: expected %0d, got %0d", want.slope, slope);
        errors++;
      end
      if (boost_seen !== want.boost) begin
        $error("boost_active: expected %0b, got %0b", want.boost, boost_seen);
        errors++;
      end
    endfunction

    function int pending();
      return expected_trend.size();
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [stbd_pkg::LEVEL_W-1:0] in_level_sample;
  logic [stbd_pkg::TIME_W-1:0]         in_time_ms;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [stbd_pkg::SLOPE_W-1:0] out_smoothed_slope;
  logic                                out_boost_active;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [3:0]                          paddr;
  logic [31:0]                         pwdata;
  logic [31:0]                         prdata;
  logic                                pready;

  trend_predictor sb = new();

  bit                          no_idle;
  bit                          held_off;
  int                          walk_level;
  logic [stbd_pkg::TIME_W-1:0] walk_stamp;
  int                          trend;
  int                          seg_left;

  slope_trend_boost_detector_top #(
    .SLOPE_FRAC_BITS (SLOPE_FRAC),
    .GAIN_FRAC_BITS  (GAIN_FRAC)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_level_sample    (in_level_sample),
    .in_time_ms         (in_time_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_smoothed_slope (out_smoothed_slope),
    .out_boost_active   (out_boost_active),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** slope_trend_boost_detector_top: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_sample(in_level_sample, in_time_ms);
    if (rst_n && out_valid && out_ready) sb.check_result(out_smoothed_slope, out_boost_active);
  end

  function automatic int idle_gap();
    return no_idle ? 0 : int'($urandom_range(0, 19));
  endfunction

  // random back-pressure, and a result held back once for a long stretch so that the input stalls
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = idle_gap();
      if (!held_off && sb.taken >= 200) begin
        gap      = HOLD_OFF_CYCLES;
        held_off = 1'b1;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_sample(input int level, input logic [stbd_pkg::TIME_W-1:0] stamp,
                             input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_level_sample <= level[stbd_pkg::LEVEL_W-1:0];
    in_time_ms      <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // trending walk with timing faults and full-range noise mixed in
  task automatic next_sample(output int level, output logic [stbd_pkg::TIME_W-1:0] stamp);
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (seg_left == 0) begin
      trend    = int'($urandom_range(0, 600)) - 300;
      seg_left = $urandom_range(5, 60);
    end
    seg_left--;
    v = walk_level + trend + int'($urandom_range(0, 40)) - 20;
    if (pick < 4) v = int'($urandom_range(0, 65535)) - 32768;
    else if (pick < 6) v = $urandom_range(0, 1) ? 32767 : -32768;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    walk_level = v;
    if (pick >= 80 && pick < 85) walk_stamp = walk_stamp;
    else if (pick >= 85 && pick < 90) walk_stamp = walk_stamp - $urandom_range(1, 50);
    else if (pick >= 90 && pick < 93) walk_stamp = $urandom;
    else if (pick >= 93 && pick < 95) walk_stamp = walk_stamp + $urandom_range(1000, 100000);
    else walk_stamp = walk_stamp + $urandom_range(1, 20);
    level = walk_level;
    stamp = walk_stamp;
  endtask

  task automatic run_phase(input int n, input logic [31:0] gain, input logic [31:0] to_boost,
                           input logic [31:0] to_normal, input bit calm);
    int                          level;
    logic [stbd_pkg::TIME_W-1:0] stamp;
    while (sb.pending() != 0) @(posedge clk);
    cfg_write(stbd_pkg::REG_GAIN, gain);
    cfg_write(stbd_pkg::REG_TO_BOOST, to_boost);
    cfg_write(stbd_pkg::REG_TO_NORMAL, to_normal);
    no_idle = calm;
    repeat (n) begin
      next_sample(level, stamp);
      send_sample(level, stamp, idle_gap());
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_level_sample = '0;
    in_time_ms      = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    no_idle         = 1'b0;
    held_off        = 1'b0;
    walk_level      = 0;
    walk_stamp      = '0;
    trend           = 0;
    seg_left        = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_sample(0, 32'd0, idle_gap());
    send_sample(32767, 32'd1, idle_gap());
    send_sample(-32768, 32'd2, idle_gap());
    send_sample(-32768, 32'd2, idle_gap());
    send_sample(100, 32'd1, idle_gap());
    send_sample(100, 32'h8000_0001, idle_gap());
    send_sample(5000, 32'h0000_0000, idle_gap());
    send_sample(-5000, 32'hFFFF_FFFF, idle_gap());
    send_sample(-4990, 32'd9, idle_gap());
    send_sample(-4997, 32'd12, idle_gap());
    send_sample(-4990, 32'd15, idle_gap());
    send_sample(32767, 32'd1_000_015, idle_gap());
    send_sample(-32768, 32'd1_000_016, idle_gap());
    send_sample(-32768, 32'hFFFF_FFFF, idle_gap());
    @(negedge clk);
    in_valid <= 1'b0;

    walk_stamp = 32'd20;
    run_phase(150, 32'd65535, 32'd1, 32'd1, 1'b0);
    run_phase(80, 32'd0, 32'd1023, 32'd1023, 1'b1);
    run_phase(250, 32'd6000, 32'd4, 32'd3, 1'b0);
    walk_stamp = 32'hFFFF_F000;
    run_phase(200, 32'd30000, 32'd25, 32'd12, 1'b0);
    run_phase(200, 32'(stbd_pkg::GAIN_RST), 32'(stbd_pkg::TO_BOOST_RST),
              32'(stbd_pkg::TO_NORMAL_RST), 1'b0);

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0)
      $display("** slope_trend_boost_detector_top: PASSED **");
    else
      $display("** slope_trend_boost_detector_top: FAILED **");
    $finish;
  end

endmodule
